[hdl/gdad_pkg.sv]
// ============================================================================
// gdad_pkg
// Shared types, constants and calendar functions for the date-advance unit.
// ============================================================================
package gdad_pkg;

    localparam int MAX_NIGHTS_DEF = 2047;
    localparam int NIGHTS_MAX     = 2047;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int NRAW_W  = 12;
    localparam int WDAY_W  = 3;
    localparam int K_W     = 7;
    localparam int J_W     = 8;
    localparam int SUM_W   = 11;

    localparam logic [DAY_W-1:0]   DEF_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] DEF_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  DEF_YEAR  = 14'd1900;
    localparam logic [K_W-1:0]     DEF_K     = 7'd0;
    localparam logic [J_W-1:0]     DEF_J     = 8'd19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [K_W-1:0] K_LAST = 7'd99;

    localparam logic [12:0] DIV100_MUL   = 13'd5242;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [DAY_W-1:0]          start_day;
        logic [MONTH_W-1:0]        start_month;
        logic [YEAR_W-1:0]         start_year;
        logic signed [NRAW_W-1:0]  nights;
    } t_in;

    typedef struct packed {
        logic                 start_valid;
        logic                 negative_error;
        logic [DAY_W-1:0]     end_day;
        logic [MONTH_W-1:0]   end_month;
        logic [YEAR_W-1:0]    end_year;
        logic [WDAY_W-1:0]    start_weekday;
        logic [WDAY_W-1:0]    end_weekday;
    } t_out;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIVE  = 10'b0000000010,
        S_DIVF  = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_SSUM  = 10'b0000010000,
        S_SMOD  = 10'b0000100000,
        S_ADV   = 10'b0001000000,
        S_ESUM  = 10'b0010000000,
        S_EMOD  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_est;
        logic div_fix;
        logic check;
        logic wsum;
        logic wmod_start;
        logic wmod_end;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
    } t_stat;

    function automatic logic f_leap(input logic [K_W-1:0] k, input logic [J_W-1:0] j,
                                    input logic [1:0] y_lo);
        logic r;
        if (k == '0) begin
            r = (j[1:0] == 2'd0);
        end else begin
            r = (y_lo == 2'd0);
        end
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] f_days_in(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        if (m == '0 || m > MONTH_DEC) begin
            r = '0;
        end else if (m == MONTH_FEB && leap) begin
            r = 5'd29;
        end else begin
            r = MONTH_LEN[m];
        end
        return r;
    endfunction

    function automatic logic [5:0] f_zeller_month(input logic [MONTH_W-1:0] m);
        logic [5:0] r;
        case (m)
            4'd1:    r = 6'd36;
            4'd2:    r = 6'd39;
            4'd3:    r = 6'd10;
            4'd4:    r = 6'd13;
            4'd5:    r = 6'd15;
            4'd6:    r = 6'd18;
            4'd7:    r = 6'd20;
            4'd8:    r = 6'd23;
            4'd9:    r = 6'd26;
            4'd10:   r = 6'd28;
            4'd11:   r = 6'd31;
            4'd12:   r = 6'd33;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/gdad_ctrl.sv]
// ============================================================================
// gdad_ctrl
// Sequencer: steps the datapath through split, check, weekday and advance.
// ============================================================================
module gdad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  gdad_pkg::t_stat  i_stat,
    output logic             busy,
    output logic             o_valid,
    output gdad_pkg::t_cmd   o_cmd
);

    gdad_pkg::t_state r_state;
    gdad_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            gdad_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = gdad_pkg::S_DIVE;
                end
            end
            gdad_pkg::S_DIVE: begin
                o_cmd.div_est = 1'b1;
                n_state       = gdad_pkg::S_DIVF;
            end
            gdad_pkg::S_DIVF: begin
                o_cmd.div_fix = 1'b1;
                n_state       = gdad_pkg::S_CHECK;
            end
            gdad_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = gdad_pkg::S_SSUM;
            end
            gdad_pkg::S_SSUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = gdad_pkg::S_SMOD;
            end
            gdad_pkg::S_SMOD: begin
                o_cmd.wmod_start = 1'b1;
                n_state          = gdad_pkg::S_ADV;
            end
            gdad_pkg::S_ADV: begin
                if (i_stat.n_zero) begin
                    n_state = gdad_pkg::S_ESUM;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            gdad_pkg::S_ESUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = gdad_pkg::S_EMOD;
            end
            gdad_pkg::S_EMOD: begin
                o_cmd.wmod_end = 1'b1;
                n_state        = gdad_pkg::S_DONE;
            end
            gdad_pkg::S_DONE: begin
                n_state = gdad_pkg::S_IDLE;
            end
            default: begin
                n_state = gdad_pkg::S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != gdad_pkg::S_IDLE);
    assign o_valid = (r_state == gdad_pkg::S_DONE);

endmodule

[hdl/gdad_dpath.sv]
// ============================================================================
// gdad_dpath
// Date registers, year split by 100, validity check, month-step advance and
// weekday arithmetic.
// ============================================================================
module gdad_dpath #(
    parameter int MAX_NIGHTS = gdad_pkg::MAX_NIGHTS_DEF
) (
    input  logic             i_clk,
    input  gdad_pkg::t_in    i_in,
    input  gdad_pkg::t_cmd   i_cmd,
    output gdad_pkg::t_stat  o_stat,
    output gdad_pkg::t_out   o_result
);

    localparam int NSAT = (MAX_NIGHTS < gdad_pkg::NIGHTS_MAX) ? MAX_NIGHTS
                                                              : gdad_pkg::NIGHTS_MAX;
    localparam int NW   = $clog2(NSAT + 1);

    logic [gdad_pkg::DAY_W-1:0]   r_d;
    logic [gdad_pkg::MONTH_W-1:0] r_m;
    logic [gdad_pkg::YEAR_W-1:0]  r_y;
    logic [gdad_pkg::NRAW_W-1:0]  r_nraw;
    logic [NW-1:0]                r_n;
    logic [gdad_pkg::J_W-1:0]     r_qest;
    logic [gdad_pkg::K_W-1:0]     r_k;
    logic [gdad_pkg::J_W-1:0]     r_j;
    logic                         r_valid;
    logic                         r_neg;
    logic [gdad_pkg::SUM_W-1:0]   r_sum;
    logic [gdad_pkg::WDAY_W-1:0]  r_sw;
    logic [gdad_pkg::WDAY_W-1:0]  r_ew;

    logic [26:0]                  prod;
    logic [gdad_pkg::YEAR_W-1:0]  q100;
    logic [gdad_pkg::YEAR_W-1:0]  rdiv;
    logic                         leap;
    logic [gdad_pkg::DAY_W-1:0]   dim;
    logic                         date_ok;
    logic [NW-1:0]                n_sat;
    logic [gdad_pkg::DAY_W-1:0]   rem;
    logic [11:0]                  n_ext;
    logic [11:0]                  rem_ext;
    logic                         wrap_month;
    logic [gdad_pkg::K_W-1:0]     kz;
    logic [gdad_pkg::J_W-1:0]     jz;
    logic [gdad_pkg::SUM_W-1:0]   sum;
    logic [6:0]                   fold_a;
    logic [4:0]                   fold_b;
    logic [3:0]                   fold_c;
    logic [2:0]                   h;
    logic [gdad_pkg::WDAY_W-1:0]  wday;

    assign prod = 27'(r_y) * 27'(gdad_pkg::DIV100_MUL);
    assign q100 = 14'(14'(r_qest) * 14'd100);
    assign rdiv = r_y - q100;

    assign leap    = gdad_pkg::f_leap(r_k, r_j, r_y[1:0]);
    assign dim     = gdad_pkg::f_days_in(r_m, leap);
    assign date_ok = (r_y != '0) && (r_m >= gdad_pkg::MONTH_JAN) &&
                     (r_m <= gdad_pkg::MONTH_DEC) && (r_d != '0) && (r_d <= dim);

    assign n_sat = (r_nraw[10:0] > 11'(NSAT)) ? NW'(NSAT) : NW'(r_nraw[10:0]);

    assign rem        = dim - r_d;
    assign n_ext      = 12'(r_n);
    assign rem_ext    = 12'(rem);
    assign wrap_month = (n_ext > rem_ext);

    always_comb begin
        kz = r_k;
        jz = r_j;
        if (r_m < gdad_pkg::MONTH_MAR) begin
            if (r_k == '0) begin
                kz = gdad_pkg::K_LAST;
                jz = r_j - 8'd1;
            end else begin
                kz = r_k - 7'd1;
            end
        end
    end

    assign sum = 11'(r_d) + 11'(gdad_pkg::f_zeller_month(r_m)) + 11'(kz) +
                 11'(kz[6:2]) + 11'(jz[7:2]) + 11'({jz, 2'b00}) + 11'(jz);

    assign fold_a = 7'(r_sum[10:6]) + 7'(r_sum[5:0]);
    assign fold_b = 5'(fold_a[6:3]) + 5'(fold_a[2:0]);
    assign fold_c = 4'(fold_b[4:3]) + 4'(fold_b[2:0]);
    assign h      = (fold_c >= 4'd7) ? 3'(fold_c - 4'd7) : fold_c[2:0];
    assign wday   = (h == 3'd0) ? 3'd6 : h - 3'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d    <= i_in.start_day;
            r_m    <= i_in.start_month;
            r_y    <= i_in.start_year;
            r_nraw <= i_in.nights;
        end else if (i_cmd.check) begin
            r_valid <= date_ok;
            r_neg   <= r_nraw[11];
            r_n     <= r_nraw[11] ? '0 : n_sat;
            if (!date_ok) begin
                r_d <= gdad_pkg::DEF_DAY;
                r_m <= gdad_pkg::DEF_MONTH;
                r_y <= gdad_pkg::DEF_YEAR;
                r_k <= gdad_pkg::DEF_K;
                r_j <= gdad_pkg::DEF_J;
            end
        end else if (i_cmd.adv) begin
            if (wrap_month) begin
                r_n <= NW'(n_ext - rem_ext - 12'd1);
                r_d <= gdad_pkg::DEF_DAY;
                if (r_m == gdad_pkg::MONTH_DEC) begin
                    r_m <= gdad_pkg::MONTH_JAN;
                    r_y <= r_y + 14'd1;
                    if (r_k == gdad_pkg::K_LAST) begin
                        r_k <= '0;
                        r_j <= r_j + 8'd1;
                    end else begin
                        r_k <= r_k + 7'd1;
                    end
                end else begin
                    r_m <= r_m + 4'd1;
                end
            end else begin
                r_n <= '0;
                r_d <= 5'(12'(r_d) + n_ext);
            end
        end

        if (i_cmd.div_est) begin
            r_qest <= prod[26:gdad_pkg::DIV100_SHIFT];
        end
        if (i_cmd.div_fix) begin
            if (rdiv >= 14'd100) begin
                r_k <= 7'(rdiv - 14'd100);
                r_j <= r_qest + 8'd1;
            end else begin
                r_k <= 7'(rdiv);
                r_j <= r_qest;
            end
        end
        if (i_cmd.wsum) begin
            r_sum <= sum;
        end
        if (i_cmd.wmod_start) begin
            r_sw <= wday;
        end
        if (i_cmd.wmod_end) begin
            r_ew <= wday;
        end
    end

    assign o_stat.n_zero = (r_n == '0);

    assign o_result.start_valid    = r_valid;
    assign o_result.negative_error = r_neg;
    assign o_result.end_day        = r_d;
    assign o_result.end_month      = r_m;
    assign o_result.end_year       = r_y;
    assign o_result.start_weekday  = r_sw;
    assign o_result.end_weekday    = r_ew;

endmodule

[hdl/gregorian_date_add_days_unit.sv]
// ============================================================================
// gregorian_date_add_days_unit
// Checks a start date, advances it by a count of nights and gives the
// weekday of both dates.
// ============================================================================
// Raise start for one cycle while busy is low to hand in a beat; busy stays
// high until the result beat has gone out. The result appears on o_result
// with o_valid high for exactly one cycle, once the unit has split the year,
// checked the date, found the start weekday, advanced the date one month
// boundary per step until the nights left fit in the month, and found the
// end weekday; at most 2047 nights (or MAX_NIGHTS, if smaller) are counted.
// The next beat is taken the cycle after the result. The result must be
// captured when o_valid is high: it cannot be held off.
module gregorian_date_add_days_unit #(
    parameter int MAX_NIGHTS = gdad_pkg::MAX_NIGHTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  gdad_pkg::t_in   i_in,
    output gdad_pkg::t_out  o_result,
    output logic            o_valid
);

    gdad_pkg::t_cmd  cmd;
    gdad_pkg::t_stat stat;

    gdad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    gdad_dpath #(
        .MAX_NIGHTS (MAX_NIGHTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    a_end_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.end_day != 5'd0) && (o_result.end_month != 4'd0) &&
                    (o_result.end_month <= 4'd12) && (o_result.end_weekday <= 3'd6))
        else $error("end date out of range");

    a_neg_same_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.negative_error) |->
            (o_result.end_weekday == o_result.start_weekday))
        else $error("negative count changed the weekday");
`endif

endmodule
